>>> rtl/bpra_pkg.sv
// Package for the bitmap page run allocator: shared constants, payload
// structs, state enum and helper types. No dependencies.
package bpra_pkg;

    localparam int TOTAL_PAGES_DEF = 4096;
    localparam int NUM_REGIONS_DEF = 3;
    localparam int PAGE_SHIFT_DEF  = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int MAX_REGIONS     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [12:0] page_count;
        logic [31:0] free_address;
    } t_req;

    typedef struct packed {
        logic [31:0] page_address;
        logic        status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RSETUP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_FIND,
        S_MOD_RD,
        S_MOD_WR,
        S_DONE
    } t_state;

    // Memory access request from the controller to the bitmap memory.
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [31:0] wr_data;
    } t_mem_ctl;

endpackage

>>> rtl/bpra_bitmap_mem.sv
// Free bitmap storage: one synchronous RAM of 32-bit words with a registered read.
// Depends on bpra_pkg.
module bpra_bitmap_mem #(
    parameter int WORDS  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                     i_clk,
    input  logic [ADDR_W-1:0]        i_addr,
    input  bpra_pkg::t_mem_ctl       i_ctl,
    output logic [31:0]              o_rd_data
);
    import bpra_pkg::*;

    logic [31:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_addr];
        end
    end

endmodule

>>> rtl/bpra_ctrl.sv
// Allocator sequencer: clearing pass, region walk, page-by-page first-fit scan
// and read-modify-write of bitmap words. Depends on bpra_pkg.
module bpra_ctrl #(
    parameter int TOTAL_PAGES = 4096,
    parameter int NUM_REGIONS = 3,
    parameter int PAGE_SHIFT  = 12,
    parameter int PG_W        = 13,
    parameter int ADDR_W      = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  bpra_pkg::t_req           i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output bpra_pkg::t_rsp           o_rsp,
    input  logic [1:0]               i_region_count,
    input  logic [19:0]              i_base [bpra_pkg::MAX_REGIONS],
    input  logic [12:0]              i_pages [bpra_pkg::MAX_REGIONS],
    output logic [ADDR_W-1:0]        o_mem_addr,
    output bpra_pkg::t_mem_ctl       o_mem_ctl,
    input  logic [31:0]              i_mem_rd_data
);
    import bpra_pkg::*;

    localparam int WORDS = (TOTAL_PAGES + 31) / 32;
    localparam logic [PG_W-1:0] TOTAL = PG_W'(TOTAL_PAGES);

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    t_req  r_req, n_req;
    t_rsp  r_rsp, n_rsp;
    logic  r_rsp_valid, n_rsp_valid;
    logic [1:0] r_reg, n_reg;
    logic [PG_W-1:0] r_off, n_off;       // bit offset of current region
    logic [PG_W-1:0] r_len, n_len;       // clipped length of current region
    logic [PG_W-1:0] r_j, n_j;           // page index inside the region
    logic [PG_W-1:0] r_run, n_run;
    logic [PG_W-1:0] r_start, n_start;
    logic [PG_W-1:0] r_end, n_end;       // end index (exclusive) of modify range
    logic            r_set, n_set;       // modify sets bits (free) or clears them

    logic [1:0]       n_use;
    logic [PG_W-1:0]  room, plen, clen;
    logic [PG_W-1:0]  pos_abs, word_base, lo, hi;
    logic [ADDR_W-1:0] word_idx;
    logic [31:0]      mask;
    logic [31:0]      cur_bit_free;
    logic [52:0]      rbase, rlim, addr_ext;
    logic [PG_W-1:0]  fpos, fend;

    assign n_use = (i_region_count > 2'(NUM_REGIONS)) ? 2'(NUM_REGIONS) : i_region_count;

    // Clipped length of region r_reg starting at offset r_off.
    always_comb begin
        room = TOTAL - r_off;
        plen = PG_W'(i_pages[r_reg]);
        clen = (plen > room) ? room : plen;
    end

    // Free-side bounds, exact width without wrap.
    always_comb begin
        rbase    = 53'(i_base[r_reg]) << PAGE_SHIFT;
        rlim     = rbase + (53'(r_len) << PAGE_SHIFT);
        addr_ext = 53'(r_req.free_address);
        fpos     = PG_W'((addr_ext - rbase) >> PAGE_SHIFT);
        fend     = ((r_len - fpos) < r_req.page_count) ? r_len : fpos + r_req.page_count;
    end

    // Modify mask for the word holding page r_off + r_j, over [r_j, r_end).
    always_comb begin
        pos_abs   = r_off + r_j;
        word_idx  = ADDR_W'(pos_abs >> 5);
        word_base = {pos_abs[PG_W-1:5], 5'd0};
        lo        = pos_abs;
        hi        = r_off + r_end;
        for (int b = 0; b < 32; b++) begin
            mask[b] = ((word_base + PG_W'(b)) >= lo) && ((word_base + PG_W'(b)) < hi);
        end
        cur_bit_free = i_mem_rd_data >> pos_abs[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rsp_valid <= n_rsp_valid;
        end
        r_req <= n_req; r_rsp <= n_rsp; r_reg <= n_reg; r_off <= n_off;
        r_len <= n_len; r_j <= n_j; r_run <= n_run; r_start <= n_start;
        r_end <= n_end; r_set <= n_set;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_req = r_req; n_rsp = r_rsp;
        n_rsp_valid = r_rsp_valid; n_reg = r_reg; n_off = r_off; n_len = r_len;
        n_j = r_j; n_run = r_run; n_start = r_start; n_end = r_end; n_set = r_set;
        o_mem_addr = word_idx;
        o_mem_ctl  = '0;
        o_req_ready = 1'b0;
        if (r_rsp_valid && i_rsp_ready) n_rsp_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_mem_addr = r_clr;
                o_mem_ctl.wr_en = 1'b1;
                o_mem_ctl.wr_data = '1;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == WORDS - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = !r_rsp_valid;
                if (i_req_valid && !r_rsp_valid) begin
                    n_req = i_req;
                    n_reg = '0;
                    n_off = '0;
                    n_rsp.page_address = '0;
                    n_rsp.status = STATUS_FAIL;
                    n_state = S_RSETUP;
                end
            end
            S_RSETUP: begin
                if (r_reg >= n_use || (r_req.kind == KIND_ALLOC && r_req.page_count == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_len = clen;
                    n_j = '0; n_run = '0;
                    n_state = (r_req.kind == KIND_ALLOC) ? S_SCAN_RD : S_FREE_FIND;
                end
            end
            S_SCAN_RD: begin
                if (r_j >= r_len) begin
                    n_off = r_off + r_len;
                    n_reg = r_reg + 1'b1;
                    n_state = S_RSETUP;
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                // One page per cycle while staying in the read word.
                if (cur_bit_free[0]) begin
                    if (r_run == '0) n_start = r_j;
                    n_run = r_run + 1'b1;
                end else begin
                    n_run = '0;
                end
                n_j = r_j + 1'b1;
                if (cur_bit_free[0] && (r_run + 1'b1) == r_req.page_count) begin
                    n_j = (r_run == '0) ? r_j : r_start;
                    n_end = r_j + 1'b1;
                    n_set = 1'b0;
                    n_rsp.page_address = 32'((64'(i_base[r_reg]) +
                        64'((r_run == '0) ? r_j : r_start)) << PAGE_SHIFT);
                    n_rsp.status = STATUS_OK;
                    n_state = S_MOD_RD;
                end else if ((r_j + 1'b1) >= r_len) begin
                    n_state = S_SCAN_RD;
                end else if (pos_abs[4:0] == 5'd31) begin
                    n_state = S_SCAN_RD;
                end else begin
                    // Next bit of the same word: hold the read data.
                    o_mem_ctl.rd_en = 1'b0;
                end
            end
            S_FREE_FIND: begin
                if (addr_ext >= rbase && addr_ext < rlim) begin
                    n_rsp.status = STATUS_OK;
                    n_j = fpos;
                    n_end = fend;
                    n_set = 1'b1;
                    n_state = (fpos < fend) ? S_MOD_RD : S_DONE;
                end else begin
                    n_off = r_off + r_len;
                    n_reg = r_reg + 1'b1;
                    n_state = S_RSETUP;
                end
            end
            S_MOD_RD: begin
                if (r_j >= r_end) begin
                    n_state = S_DONE;
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_state = S_MOD_WR;
                end
            end
            S_MOD_WR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_ctl.wr_data = r_set ? (i_mem_rd_data | mask) : (i_mem_rd_data & ~mask);
                n_j = word_base + 6'd32 - r_off;
                n_state = S_MOD_RD;
            end
            S_DONE: begin
                if (!r_rsp_valid) begin
                    n_rsp_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;

    a_rsp_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.status == STATUS_FAIL |-> r_rsp.page_address == '0)
        else $error("failed transaction carries nonzero address");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_req_ready)
        else $error("ready while busy");
    a_no_wr_rd_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.wr_en && o_mem_ctl.rd_en))
        else $error("read and write in one cycle");
endmodule

>>> rtl/bitmap_page_run_allocator.sv
// Top level of the bitmap page run allocator: configuration registers,
// sequencer and bitmap memory. Depends on bpra_pkg, bpra_ctrl, bpra_bitmap_mem.
//
//  channel   direction  handshake                   payload
//  request   in         i_req_valid / o_req_ready   i_req (t_req)
//  response  out        o_rsp_valid / i_rsp_ready   o_rsp (t_rsp)
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// Allocate: each 32-page word is read and its pages scanned in turn, then
// each modified word is read and written back; free: regions are checked
// in turn, then each word touched is read and written back. One transaction
// is in flight at a time. After reset a clearing pass fills the RAM with
// ones; no request is taken until it ends. A stalled response holds intake.
module bitmap_page_run_allocator #(
    parameter int TOTAL_PAGES = bpra_pkg::TOTAL_PAGES_DEF,
    parameter int NUM_REGIONS = bpra_pkg::NUM_REGIONS_DEF,
    parameter int PAGE_SHIFT  = bpra_pkg::PAGE_SHIFT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  bpra_pkg::t_req                   i_req,
    output logic                             o_rsp_valid,
    input  logic                             i_rsp_ready,
    output bpra_pkg::t_rsp                   o_rsp,
    input  logic                             i_cfg_we,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bpra_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpra_pkg::*;

    localparam int WORDS  = (TOTAL_PAGES + 31) / 32;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PG_W   = $clog2(TOTAL_PAGES + 1) + 1;

    logic [1:0]  r_region_count;
    logic [19:0] r_base  [MAX_REGIONS];
    logic [12:0] r_pages [MAX_REGIONS];
    logic [ADDR_W-1:0] mem_addr;
    t_mem_ctl          mem_ctl;
    logic [31:0]       mem_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= '0;
            for (int r = 0; r < MAX_REGIONS; r++) begin
                r_base[r]  <= '0;
                r_pages[r] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_REGION_COUNT) begin
                r_region_count <= i_cfg_data[1:0];
            end else if (i_cfg_idx <= CFG_IDX_W'(2 * MAX_REGIONS)) begin
                if (i_cfg_idx[0]) r_base[2'((i_cfg_idx - 1'b1) >> 1)] <= i_cfg_data;
                else r_pages[2'((i_cfg_idx - 1'b1) >> 1)] <= i_cfg_data[12:0];
            end
        end
    end

    bpra_ctrl #(.TOTAL_PAGES(TOTAL_PAGES), .NUM_REGIONS(NUM_REGIONS),
                .PAGE_SHIFT(PAGE_SHIFT), .PG_W(PG_W), .ADDR_W(ADDR_W)) u_ctrl (
        .i_clk, .i_rst_n, .i_req_valid, .o_req_ready, .i_req,
        .o_rsp_valid, .i_rsp_ready, .o_rsp,
        .i_region_count(r_region_count), .i_base(r_base), .i_pages(r_pages),
        .o_mem_addr(mem_addr), .o_mem_ctl(mem_ctl), .i_mem_rd_data(mem_rd)
    );

    bpra_bitmap_mem #(.WORDS(WORDS), .ADDR_W(ADDR_W)) u_mem (
        .i_clk, .i_addr(mem_addr), .i_ctl(mem_ctl), .o_rd_data(mem_rd)
    );

endmodule
